// ===== hdl/rsq_pkg.sv =====
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types, codes and the quarter-wave sine generator for the rotated
// sprite quad setup block.
// ----------------------------------------------------------------------------
package rsq_pkg;

    typedef enum logic {
        OP_DRAW        = 1'b0,
        OP_BEGIN_BATCH = 1'b1
    } op_t;

    // corner order on the output
    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_TL = 2'd1,
        CORNER_TR = 2'd2,
        CORNER_BR = 2'd3
    } corner_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // per-sprite attributes that ride along to every vertex
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] rgba;
        logic [15:0] tex_left;
        logic [15:0] tex_top;
        logic [15:0] tex_right;
        logic [15:0] tex_bottom;
        logic [6:0]  slot_hi;
        logic        full;
    } attr_t;

    typedef struct packed {
        attr_t       attr;
        logic [30:0] w;
        logic [30:0] h;
    } spr_t;

    // one queued sprite: size times |cos| / |sin| magnitudes plus signs
    typedef struct packed {
        logic [60:0] m_wc;
        logic [60:0] m_hs;
        logic [60:0] m_ws;
        logic [60:0] m_hc;
        logic        neg_cs;
        logic        neg_sn;
        attr_t       attr;
    } qent_t;

    // Taylor series of sin(x), x in Q2.30, clamped to [0, 1.0]
    function automatic logic [30:0] taylor_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [30:0] r;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd210;
        s  = s - t;
        if (s[63])
            r = '0;
        else if (s > {33'd0, ONE_Q30})
            r = ONE_Q30;
        else
            r = s[30:0];
        return r;
    endfunction

endpackage

// ===== hdl/rsq_queue.sv =====
// ----------------------------------------------------------------------------
// rsq_queue
// Two-entry request queue between the sprite front end and the vertex back end.
// ----------------------------------------------------------------------------
module rsq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rsq_pkg::qent_t din,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output rsq_pkg::qent_t dout
);

    localparam int DEPTH = 2;

    rsq_pkg::qent_t mem [0:DEPTH-1];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full     = (count_reg == 2'(DEPTH));
    assign nonempty = (count_reg != 2'd0);
    assign dout     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'(DEPTH) || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a push");

endmodule

// ===== hdl/rsq_front.sv =====
// ----------------------------------------------------------------------------
// rsq_front
// Accepts requests, runs the sprite counter, looks up sine and cosine and
// forms the four size-by-trig products that go into the queue.
// ----------------------------------------------------------------------------
module rsq_front #(
    parameter int CHUNK_SPRITES      = 128,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           opcode,
    input  logic [31:0]    center_x,
    input  logic [31:0]    center_y,
    input  logic [30:0]    sprite_width,
    input  logic [30:0]    sprite_height,
    input  logic [15:0]    rotation,
    input  logic [31:0]    rgba,
    input  logic [15:0]    tex_left,
    input  logic [15:0]    tex_top,
    input  logic [15:0]    tex_right,
    input  logic [15:0]    tex_bottom,
    output logic           q_push,
    output rsq_pkg::qent_t q_data,
    input  logic           q_full
);

    localparam int CNT_W  = (CHUNK_SPRITES > 1) ? $clog2(CHUNK_SPRITES) : 1;
    localparam int N_W    = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PROD_W = 14 + N_W;

    // quarter-wave table, T(0)=0 .. T(N)=1.0
    logic [30:0] sine_rom [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_rom
        if (k == 0)
        begin : g_zero
            assign sine_rom[k] = '0;
        end
        else if (k == SINE_TABLE_ENTRIES)
        begin : g_one
            assign sine_rom[k] = rsq_pkg::ONE_Q30;
        end
        else
        begin : g_mid
            localparam logic [63:0] XK =
                (64'(k) * rsq_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
            localparam logic [30:0] TK = rsq_pkg::taylor_sine(XK);
            assign sine_rom[k] = TK;
        end
    end

    logic             accept;
    logic             draw_acc;
    logic             f1_en;
    logic             f2_en;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_last;
    logic [PROD_W-1:0] idx_prod;
    logic [N_W-1:0]   sidx;
    logic [N_W-1:0]   cidx;
    rsq_pkg::spr_t    spr_in;

    logic             f1_valid_reg;
    rsq_pkg::spr_t    f1_spr_reg;
    logic [1:0]       f1_quad_reg;
    logic [N_W-1:0]   f1_sidx_reg;
    logic [N_W-1:0]   f1_cidx_reg;

    logic             f2_valid_reg;
    rsq_pkg::spr_t    f2_spr_reg;
    logic [1:0]       f2_quad_reg;
    logic [30:0]      f2_smag_reg;
    logic [30:0]      f2_cmag_reg;

    logic [30:0]      cos_mag;
    logic [30:0]      sin_mag;
    logic [60:0]      p_wc;
    logic [60:0]      p_hs;
    logic [60:0]      p_ws;
    logic [60:0]      p_hc;

    assign f2_en    = !f2_valid_reg || !q_full;
    assign f1_en    = !f1_valid_reg || f2_en;
    assign in_stall = !f1_en;
    assign accept   = in_valid && !in_stall;
    assign draw_acc = accept && (opcode == rsq_pkg::OP_DRAW);

    assign cnt_last = (cnt_reg == CNT_W'(CHUNK_SPRITES - 1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (opcode == rsq_pkg::OP_BEGIN_BATCH || cnt_last)
                cnt_next = '0;
            else
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // table step = floor(phase * N / 2^14)
    assign idx_prod = PROD_W'(rotation[13:0]) * PROD_W'(SINE_TABLE_ENTRIES);
    assign sidx     = idx_prod[PROD_W-1:14];
    assign cidx     = N_W'(SINE_TABLE_ENTRIES) - sidx;

    always_comb
    begin
        spr_in.attr.cx         = center_x;
        spr_in.attr.cy         = center_y;
        spr_in.attr.rgba       = rgba;
        spr_in.attr.tex_left   = tex_left;
        spr_in.attr.tex_top    = tex_top;
        spr_in.attr.tex_right  = tex_right;
        spr_in.attr.tex_bottom = tex_bottom;
        spr_in.attr.slot_hi    = 7'(cnt_reg);
        spr_in.attr.full       = cnt_last;
        spr_in.w               = sprite_width;
        spr_in.h               = sprite_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (f1_en)
                f1_valid_reg <= draw_acc;
            if (f2_en)
                f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_en)
        begin
            f1_spr_reg  <= spr_in;
            f1_quad_reg <= rotation[15:14];
            f1_sidx_reg <= sidx;
            f1_cidx_reg <= cidx;
        end
        if (f2_en)
        begin
            f2_spr_reg  <= f1_spr_reg;
            f2_quad_reg <= f1_quad_reg;
            f2_smag_reg <= sine_rom[f1_sidx_reg];
            f2_cmag_reg <= sine_rom[f1_cidx_reg];
        end
    end

    // odd quadrants swap sine and cosine magnitudes
    assign cos_mag = f2_quad_reg[0] ? f2_smag_reg : f2_cmag_reg;
    assign sin_mag = f2_quad_reg[0] ? f2_cmag_reg : f2_smag_reg;

    // magnitudes are at most 1.0 in Q1.30, so each product fits in 61 bits
    assign p_wc = 61'(f2_spr_reg.w) * 61'(cos_mag);
    assign p_hs = 61'(f2_spr_reg.h) * 61'(sin_mag);
    assign p_ws = 61'(f2_spr_reg.w) * 61'(sin_mag);
    assign p_hc = 61'(f2_spr_reg.h) * 61'(cos_mag);

    always_comb
    begin
        q_data.m_wc   = p_wc;
        q_data.m_hs   = p_hs;
        q_data.m_ws   = p_ws;
        q_data.m_hc   = p_hc;
        q_data.neg_cs = f2_quad_reg[1] ^ f2_quad_reg[0];
        q_data.neg_sn = f2_quad_reg[1];
        q_data.attr   = f2_spr_reg.attr;
    end

    assign q_push = f2_valid_reg && !q_full;

endmodule

// ===== hdl/rsq_back.sv =====
// ----------------------------------------------------------------------------
// rsq_back
// Walks the four corners of the queued sprite, one vertex per cycle when not
// stalled by out_stall: signed offset sum, round half up, add to center, saturate.
// ----------------------------------------------------------------------------
module rsq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rsq_pkg::qent_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    vertex_x,
    output logic [31:0]    vertex_y,
    output logic [31:0]    vertex_rgba,
    output logic [15:0]    vertex_u,
    output logic [15:0]    vertex_v,
    output logic [8:0]     vertex_slot,
    output logic           last_of_sprite,
    output logic           chunk_full
);

    function automatic logic [62:0] signed_term(input logic [60:0] m, input logic neg);
        logic [62:0] t;
        t = {2'b00, m};
        return neg ? (63'd0 - t) : t;
    endfunction

    // center + floor((d + 2^30) / 2^31), clamped to int32
    function automatic logic [31:0] place(input logic [31:0] c, input logic [62:0] d);
        logic [33:0] sum;
        logic [31:0] r;
        sum = {{2{c[31]}}, c} + {{2{d[62]}}, d[62:31]} + {33'd0, d[30]};
        if (sum[33] && !(sum[32] && sum[31]))
            r = 32'h8000_0000;
        else if (!sum[33] && (sum[32] || sum[31]))
            r = 32'h7FFF_FFFF;
        else
            r = sum[31:0];
        return r;
    endfunction

    logic              adv;
    logic              b1_en;
    logic              issue;
    rsq_pkg::corner_t  corner_reg;
    rsq_pkg::corner_t  corner_next;
    logic              sx_neg;
    logic              sy_neg;
    logic [62:0]       d_next;
    logic [62:0]       e_next;

    logic              b1_valid_reg;
    logic [62:0]       b1_d_reg;
    logic [62:0]       b1_e_reg;
    logic [31:0]       b1_cx_reg;
    logic [31:0]       b1_cy_reg;
    logic [31:0]       b1_rgba_reg;
    logic [15:0]       b1_u_reg;
    logic [15:0]       b1_v_reg;
    logic [8:0]        b1_slot_reg;
    logic              b1_last_reg;
    logic              b1_full_reg;

    logic              out_valid_reg;
    logic [31:0]       out_x_reg;
    logic [31:0]       out_y_reg;
    logic [31:0]       out_rgba_reg;
    logic [15:0]       out_u_reg;
    logic [15:0]       out_v_reg;
    logic [8:0]        out_slot_reg;
    logic              out_last_reg;
    logic              out_full_reg;

    assign adv   = !out_valid_reg || !out_stall;
    assign b1_en = !b1_valid_reg || adv;
    assign issue = b1_en && q_valid;
    assign q_pop = issue && (corner_reg == rsq_pkg::CORNER_BR);

    assign corner_next = issue ? rsq_pkg::corner_t'(corner_reg + 2'd1) : corner_reg;

    // x sign negative on the left edge, y sign negative on the bottom edge
    assign sx_neg = !corner_reg[1];
    assign sy_neg = !(corner_reg[1] ^ corner_reg[0]);

    assign d_next = signed_term(q_data.m_wc, sx_neg ^ q_data.neg_cs)
                  + signed_term(q_data.m_hs, !(sy_neg ^ q_data.neg_sn));
    assign e_next = signed_term(q_data.m_ws, sx_neg ^ q_data.neg_sn)
                  + signed_term(q_data.m_hc, sy_neg ^ q_data.neg_cs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= rsq_pkg::CORNER_BL;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            corner_reg <= corner_next;
            if (b1_en)
                b1_valid_reg <= q_valid;
            if (adv)
                out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_en)
        begin
            b1_d_reg    <= d_next;
            b1_e_reg    <= e_next;
            b1_cx_reg   <= q_data.attr.cx;
            b1_cy_reg   <= q_data.attr.cy;
            b1_rgba_reg <= q_data.attr.rgba;
            b1_u_reg    <= corner_reg[1] ? q_data.attr.tex_right : q_data.attr.tex_left;
            b1_v_reg    <= (corner_reg[1] ^ corner_reg[0]) ? q_data.attr.tex_top
                                                            : q_data.attr.tex_bottom;
            b1_slot_reg <= {q_data.attr.slot_hi, corner_reg};
            b1_last_reg <= (corner_reg == rsq_pkg::CORNER_BR);
            b1_full_reg <= (corner_reg == rsq_pkg::CORNER_BR) && q_data.attr.full;
        end
        if (adv)
        begin
            out_x_reg    <= place(b1_cx_reg, b1_d_reg);
            out_y_reg    <= place(b1_cy_reg, b1_e_reg);
            out_rgba_reg <= b1_rgba_reg;
            out_u_reg    <= b1_u_reg;
            out_v_reg    <= b1_v_reg;
            out_slot_reg <= b1_slot_reg;
            out_last_reg <= b1_last_reg;
            out_full_reg <= b1_full_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign vertex_x       = out_x_reg;
    assign vertex_y       = out_y_reg;
    assign vertex_rgba    = out_rgba_reg;
    assign vertex_u       = out_u_reg;
    assign vertex_v       = out_v_reg;
    assign vertex_slot    = out_slot_reg;
    assign last_of_sprite = out_last_reg;
    assign chunk_full     = out_full_reg;

    a_full_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> out_last_reg)
        else $error("chunk_full without last corner");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_slot_reg[1:0] == rsq_pkg::CORNER_BR)
        else $error("last corner slot mismatch");

    a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && corner_reg != rsq_pkg::CORNER_BR) |=> q_valid)
        else $error("sprite left the queue before its last corner");

endmodule

// ===== hdl/rotated_sprite_quad_setup.sv =====
// ----------------------------------------------------------------------------
// rotated_sprite_quad_setup
// Turns one sprite request into its four rotated corner vertices.
// ----------------------------------------------------------------------------
// A draw request yields four vertices, bottom-left, top-left, top-right,
// bottom-right, one per cycle on the output while out_stall is low; the
// single-vertex output port sets the pace of a steady stream of sprites.
// The front end takes a new request every cycle while its two-entry
// queue has room, so requests keep flowing while the back end still emits
// the vertices of earlier sprites. A begin-batch request clears the sprite
// counter and yields nothing. A sprite passes the front-end registers, the
// queue and the back-end registers before its first vertex appears. The
// sine table is a constant ROM; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_setup #(
    parameter int CHUNK_SPRITES      = 128,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [30:0]        sprite_width,
    input  logic [30:0]        sprite_height,
    input  logic [15:0]        rotation,
    input  logic [31:0]        rgba,
    input  logic [15:0]        tex_left,
    input  logic [15:0]        tex_top,
    input  logic [15:0]        tex_right,
    input  logic [15:0]        tex_bottom,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic [31:0]        vertex_rgba,
    output logic [15:0]        vertex_u,
    output logic [15:0]        vertex_v,
    output logic [8:0]         vertex_slot,
    output logic               last_of_sprite,
    output logic               chunk_full
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_nonempty;
    rsq_pkg::qent_t q_din;
    rsq_pkg::qent_t q_dout;
    logic [31:0]    vx;
    logic [31:0]    vy;

    rsq_front #(
        .CHUNK_SPRITES      (CHUNK_SPRITES),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .center_x      (center_x),
        .center_y      (center_y),
        .sprite_width  (sprite_width),
        .sprite_height (sprite_height),
        .rotation      (rotation),
        .rgba          (rgba),
        .tex_left      (tex_left),
        .tex_top       (tex_top),
        .tex_right     (tex_right),
        .tex_bottom    (tex_bottom),
        .q_push        (q_push),
        .q_data        (q_din),
        .q_full        (q_full)
    );

    rsq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .din      (q_din),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .dout     (q_dout)
    );

    rsq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_nonempty),
        .q_data         (q_dout),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vertex_x       (vx),
        .vertex_y       (vy),
        .vertex_rgba    (vertex_rgba),
        .vertex_u       (vertex_u),
        .vertex_v       (vertex_v),
        .vertex_slot    (vertex_slot),
        .last_of_sprite (last_of_sprite),
        .chunk_full     (chunk_full)
    );

    assign vertex_x = $signed(vx);
    assign vertex_y = $signed(vy);

endmodule
